@@ design/uoda_pkg.sv @@
// ----------------------------------------------------------------------------
// uoda_pkg
// Shared types, constants and month length lookup for the UTC offset date
// adjust core.
// ----------------------------------------------------------------------------
`default_nettype none

package uoda_pkg;

    localparam int unsigned YearW   = 16;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned SecondW = 6;
    localparam int unsigned OffsetW = 11;
    localparam int unsigned TodW    = 11;   // minutes of day, up to 1923 before wrap
    localparam int unsigned TotalW  = 13;   // signed sum with offset

    localparam int unsigned StampBits = YearW + MonthW + DayW + HourW + MinuteW + SecondW;
    localparam int unsigned TdataW    = ((StampBits + 7) / 8) * 8;

    localparam logic [TodW-1:0]     MinPerDay   = 11'd1440;
    localparam logic [MonthW-1:0]   MonthDec    = 4'd12;
    localparam logic [DayW-1:0]     DayFeb      = 5'd28;
    localparam logic [DayW-1:0]     DayFebLeap  = 5'd29;
    localparam logic [DayW-1:0]     DayShort    = 5'd30;
    localparam logic [DayW-1:0]     DayLong     = 5'd31;

    // floor(t/60) = (t * 1093) >> 16 for t < 1440
    localparam logic [TodW-1:0]     Recip60      = 11'd1093;
    localparam int unsigned         Recip60Shift = 16;

    // y divisible by 25 <=> (y * inv(25) mod 2^16) <= floor(65535/25)
    localparam logic [YearW-1:0]    Inv25 = 16'd23593;
    localparam logic [YearW-1:0]    Max25 = 16'd2621;

    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_FWD,
        SHIFT_BACK
    } t_shift;

    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } t_stamp;

    function automatic logic [DayW-1:0] month_days(input logic leap,
                                                   input logic [MonthW-1:0] m);
        logic [DayW-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayLong;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DayShort;
            4'd2:    len = leap ? DayFebLeap : DayFeb;
            default: len = DayShort;    // malformed month
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ design/uoda_time_calc.sv @@
// ----------------------------------------------------------------------------
// uoda_time_calc
// Adds the offset to the minutes of day, wraps into one day and splits the
// result back into hour and minute. Reports the resulting day shift.
// ----------------------------------------------------------------------------
`default_nettype none

module uoda_time_calc (
    input  wire logic [uoda_pkg::HourW-1:0]          i_hour,
    input  wire logic [uoda_pkg::MinuteW-1:0]        i_minute,
    input  wire logic signed [uoda_pkg::OffsetW-1:0] i_offset,
    output logic [uoda_pkg::HourW-1:0]               o_hour,
    output logic [uoda_pkg::MinuteW-1:0]             o_minute,
    output uoda_pkg::t_shift                         o_shift
);
    import uoda_pkg::*;

    localparam int unsigned ProdW = 2 * TodW;

    logic [TodW-1:0]          w_tod;
    logic signed [TotalW-1:0] w_total;
    logic signed [TotalW-1:0] w_wrapped;
    logic [TodW-1:0]          w_t;
    logic [ProdW-1:0]         w_prod;
    logic [TodW-1:0]          w_q;
    logic [TodW-1:0]          w_q60;
    logic [TodW-1:0]          w_rem;

    // hour * 60 as (hour << 6) - (hour << 2)
    assign w_tod = TodW'({i_hour, 6'b0}) - TodW'({i_hour, 2'b0}) + TodW'(i_minute);
    assign w_total = signed'(TotalW'(w_tod)) + TotalW'(i_offset);

    // range -1024..2946: at most two days are subtracted
    always_comb begin
        if (w_total < 0) begin
            w_wrapped = w_total + signed'(TotalW'(MinPerDay));
            o_shift   = SHIFT_BACK;
        end else if (w_total >= signed'(TotalW'({MinPerDay, 1'b0}))) begin
            w_wrapped = w_total - signed'(TotalW'({MinPerDay, 1'b0}));
            o_shift   = SHIFT_FWD;
        end else if (w_total >= signed'(TotalW'(MinPerDay))) begin
            w_wrapped = w_total - signed'(TotalW'(MinPerDay));
            o_shift   = SHIFT_FWD;
        end else begin
            w_wrapped = w_total;
            o_shift   = SHIFT_NONE;
        end
    end

    assign w_t    = w_wrapped[TodW-1:0];
    assign w_prod = ProdW'(w_t) * ProdW'(Recip60);
    assign w_q    = TodW'(w_prod[ProdW-1:Recip60Shift]);
    assign w_q60  = TodW'({w_q, 6'b0}) - TodW'({w_q, 2'b0});
    assign w_rem  = w_t - w_q60;

    assign o_hour   = w_q[HourW-1:0];
    assign o_minute = w_rem[MinuteW-1:0];

endmodule

`default_nettype wire

@@ design/uoda_date_step.sv @@
// ----------------------------------------------------------------------------
// uoda_date_step
// Moves a calendar date one day forward or back across month and year
// ends, Gregorian leap years, year wrapping modulo 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module uoda_date_step (
    input  wire logic [uoda_pkg::YearW-1:0]  i_year,
    input  wire logic [uoda_pkg::MonthW-1:0] i_month,
    input  wire logic [uoda_pkg::DayW-1:0]   i_day,
    input  wire uoda_pkg::t_shift            i_shift,
    output logic [uoda_pkg::YearW-1:0]       o_year,
    output logic [uoda_pkg::MonthW-1:0]      o_month,
    output logic [uoda_pkg::DayW-1:0]        o_day
);
    import uoda_pkg::*;

    logic [YearW-1:0]  w_mul25;
    logic              w_div25;
    logic              w_leap;
    logic [DayW-1:0]   w_len;
    logic [DayW:0]     w_day_inc;
    logic [MonthW:0]   w_month_inc;
    logic [MonthW-1:0] w_month_dec;

    // divisibility by 25 through the modular inverse
    assign w_mul25 = i_year * Inv25;
    assign w_div25 = (w_mul25 <= Max25);
    assign w_leap  = (i_year[1:0] == 2'b0) && (!w_div25 || (i_year[3:0] == 4'b0));

    assign w_len       = month_days(w_leap, i_month);
    assign w_day_inc   = {1'b0, i_day} + (DayW+1)'(1);
    assign w_month_inc = {1'b0, i_month} + (MonthW+1)'(1);
    assign w_month_dec = i_month - MonthW'(1);

    always_comb begin
        o_year  = i_year;
        o_month = i_month;
        o_day   = i_day;
        case (i_shift)
            SHIFT_FWD: begin
                if (w_day_inc > {1'b0, w_len}) begin
                    o_day = DayW'(1);
                    if (w_month_inc > {1'b0, MonthDec}) begin
                        o_month = MonthW'(1);
                        o_year  = i_year + YearW'(1);
                    end else begin
                        o_month = w_month_inc[MonthW-1:0];
                    end
                end else begin
                    o_day = w_day_inc[DayW-1:0];
                end
            end
            SHIFT_BACK: begin
                if (i_day > DayW'(1)) begin
                    o_day = i_day - DayW'(1);
                end else if (i_month > MonthW'(1)) begin
                    o_month = w_month_dec;
                    o_day   = month_days(w_leap, w_month_dec);
                end else begin
                    // December has no leap dependence
                    o_month = MonthDec;
                    o_year  = i_year - YearW'(1);
                    o_day   = month_days(1'b0, MonthDec);
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ design/utc_offset_date_adjust_core.sv @@
// ----------------------------------------------------------------------------
// utc_offset_date_adjust_core
// UTC date/time to local date/time with a signed minute offset and one-day
// rollover across month and year ends.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat goes to the input register, then to the
//   output register, which drives the result beat.
// Throughput: one beat per cycle while the sink does not stall, no gaps needed between beats.
// Input is taken whenever the input register is empty or moving on.
// Reset (synchronous, active low) empties both stages and clears the
//   offset to 0.
`default_nettype none

module utc_offset_date_adjust_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [uoda_pkg::OffsetW-1:0]  i_cfg_wdata,   // utc_offset_minutes
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // in_year, in_month, in_day, in_hour, in_minute, in_second, zero fill
    input  wire logic [uoda_pkg::TdataW-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // out_year, out_month, out_day, out_hour, out_minute, out_second, zero fill
    output logic [uoda_pkg::TdataW-1:0]        m_axis_tdata
);
    import uoda_pkg::*;

    logic signed [OffsetW-1:0] r_offset;
    logic                      r_s1_valid;
    logic                      n_s1_valid;
    t_stamp                    r_s1;
    t_stamp                    n_s1;
    logic                      r_m_valid;
    logic                      n_m_valid;
    t_stamp                    r_m;
    t_stamp                    n_m;

    logic   w_m_free;
    logic   w_s1_free;
    t_shift w_shift;

    assign w_m_free      = !r_m_valid || m_axis_tready;
    assign w_s1_free     = !r_s1_valid || w_m_free;
    assign s_axis_tready = w_s1_free;

    always_comb begin
        n_s1.year   = s_axis_tdata[15:0];
        n_s1.month  = s_axis_tdata[19:16];
        n_s1.day    = s_axis_tdata[24:20];
        n_s1.hour   = s_axis_tdata[29:25];
        n_s1.minute = s_axis_tdata[35:30];
        n_s1.second = s_axis_tdata[41:36];
    end

    uoda_time_calc u_time (
        .i_hour   (r_s1.hour),
        .i_minute (r_s1.minute),
        .i_offset (r_offset),
        .o_hour   (n_m.hour),
        .o_minute (n_m.minute),
        .o_shift  (w_shift)
    );

    uoda_date_step u_date (
        .i_year  (r_s1.year),
        .i_month (r_s1.month),
        .i_day   (r_s1.day),
        .i_shift (w_shift),
        .o_year  (n_m.year),
        .o_month (n_m.month),
        .o_day   (n_m.day)
    );

    assign n_m.second = r_s1.second;

    always_comb begin
        n_s1_valid = w_s1_free ? s_axis_tvalid : r_s1_valid;
        n_m_valid  = w_m_free ? r_s1_valid : r_m_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= signed'(i_cfg_wdata);
            end
            r_s1_valid <= n_s1_valid;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
        if (w_m_free && r_s1_valid) begin
            r_m <= n_m;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(TdataW-StampBits)'(0), r_m.second, r_m.minute, r_m.hour,
                            r_m.day, r_m.month, r_m.year};

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_m.hour < HourW'(24)))
        else $error("local hour out of range");

    a_minute_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_m.minute < MinuteW'(60)))
        else $error("local minute out of range");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed under stall");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && m_axis_tvalid && !m_axis_tready) |=> r_s1_valid)
        else $error("stage one beat lost under stall");
`endif

endmodule

`default_nettype wire

@@ test/utc_offset_date_adjust_core_tb.sv @@
// ----------------------------------------------------------------------------
// utc_offset_date_adjust_core_tb
// Drives UTC timestamps through the core under several offsets and compares
// every local date/time beat with a behavioral predictor. The run covers
// directed month, year and leap-day rollovers, then random stamps under
// varying source and sink back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_offset_date_adjust_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import uoda_pkg::*;

    localparam int MinutesPerDay = 1440;
    localparam int CycleLimit    = 500000;
    localparam int PhaseBeats    = 250;
    localparam int NumPhases     = 8;

    // Holds the local stamps still owed by the core, oldest first.
    class local_time_board;
        t_stamp due[$];
        int     offset_min = 0;
        int     errors = 0;

        function void set_offset(logic [OffsetW-1:0] raw);
            offset_min = int'($signed(raw));
        endfunction

        function int unsigned days_of(int unsigned y, int unsigned m);
            logic leap;
            leap = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
            if (m < 1 || m > 12) return 30;   // malformed month
            if (m == 2) return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
            return 31;
        endfunction

        function t_stamp to_local(t_stamp u);
            t_stamp      r;
            int          tod;
            int unsigned y;
            int unsigned m;
            int unsigned d;
            r   = u;
            y   = u.year;
            m   = u.month;
            d   = u.day;
            tod = int'(u.hour) * 60 + int'(u.minute) + offset_min;
            if (tod < 0) begin
                tod = ((tod % MinutesPerDay) + MinutesPerDay) % MinutesPerDay;
                if (d > 1) begin
                    d--;
                end else begin
                    if (m > 1) begin
                        m--;
                    end else begin
                        m = 12;
                        y = (y - 1) & 16'hFFFF;
                    end
                    d = days_of(y, m);
                end
            end else if (tod >= MinutesPerDay) begin
                tod = tod % MinutesPerDay;
                d++;
                if (d > days_of(y, m)) begin
                    d = 1;
                    m++;
                    if (m > 12) begin
                        m = 1;
                        y = (y + 1) & 16'hFFFF;
                    end
                end
            end
            r.year   = YearW'(y);
            r.month  = MonthW'(m);
            r.day    = DayW'(d);
            r.hour   = HourW'(tod / 60);
            r.minute = MinuteW'(tod % 60);
            return r;
        endfunction

        function void note_stamp(t_stamp u);
            due.push_back(to_local(u));
        endfunction

        function void cmp_field(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", fname, want, got);
                errors++;
            end
        endfunction

        function void check_local(t_stamp got);
            t_stamp want;
            if (due.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = due.pop_front();
            cmp_field("out_year",   want.year,   got.year);
            cmp_field("out_month",  want.month,  got.month);
            cmp_field("out_day",    want.day,    got.day);
            cmp_field("out_hour",   want.hour,   got.hour);
            cmp_field("out_minute", want.minute, got.minute);
            cmp_field("out_second", want.second, got.second);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [OffsetW-1:0]  i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TdataW-1:0]   s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TdataW-1:0]   m_axis_tdata;

    local_time_board sb;
    t_stamp          seen_local;
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;
    int              cycles = 0;

    utc_offset_date_adjust_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sink side: check accepted beats, then pick tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_local.year   = m_axis_tdata[15:0];
            seen_local.month  = m_axis_tdata[19:16];
            seen_local.day    = m_axis_tdata[24:20];
            seen_local.hour   = m_axis_tdata[29:25];
            seen_local.minute = m_axis_tdata[35:30];
            seen_local.second = m_axis_tdata[41:36];
            sb.check_local(seen_local);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic t_stamp mk_stamp(int y, int m, int d, int h, int mi, int s);
        t_stamp r;
        r.year   = YearW'(y);
        r.month  = MonthW'(m);
        r.day    = DayW'(d);
        r.hour   = HourW'(h);
        r.minute = MinuteW'(mi);
        r.second = SecondW'(s);
        return r;
    endfunction

    task automatic send_stamp(input t_stamp s);
        logic [TdataW-1:0] beat;
        beat = '0;
        beat[StampBits-1:0] = {s.second, s.minute, s.hour, s.day, s.month, s.year};
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_stamp(s);
    endtask

    // offset may only change once the pipe has drained
    task automatic write_offset(input logic [OffsetW-1:0] raw);
        s_axis_tvalid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= raw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_offset(raw);
    endtask

    initial begin
        t_stamp      u;
        int          ph;
        logic [10:0] off;
        sb = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // forward rollovers, +14h
        write_offset(11'(840));
        send_stamp(mk_stamp(2023, 12, 31, 23, 59, 59));
        send_stamp(mk_stamp(65535, 12, 31, 23, 0, 0));
        send_stamp(mk_stamp(2024, 2, 28, 12, 0, 1));
        send_stamp(mk_stamp(2024, 2, 29, 12, 0, 2));
        send_stamp(mk_stamp(1900, 2, 28, 15, 30, 3));
        send_stamp(mk_stamp(2000, 2, 28, 15, 30, 4));
        send_stamp(mk_stamp(2001, 0, 30, 20, 0, 5));
        send_stamp(mk_stamp(2001, 13, 30, 20, 0, 6));
        send_stamp(mk_stamp(2001, 15, 31, 20, 0, 7));
        send_stamp(mk_stamp(2010, 7, 0, 22, 0, 8));
        send_stamp(mk_stamp(2010, 4, 31, 22, 0, 9));
        send_stamp(mk_stamp(0, 6, 15, 31, 63, 63));

        // backward rollovers, -12h
        write_offset(11'(-720));
        send_stamp(mk_stamp(2024, 1, 1, 0, 0, 10));
        send_stamp(mk_stamp(0, 1, 1, 11, 59, 11));
        send_stamp(mk_stamp(2024, 3, 1, 0, 0, 12));
        send_stamp(mk_stamp(2100, 3, 1, 5, 5, 13));
        send_stamp(mk_stamp(2005, 0, 1, 1, 0, 14));
        send_stamp(mk_stamp(2005, 13, 0, 1, 0, 15));
        send_stamp(mk_stamp(2005, 15, 1, 1, 0, 16));
        send_stamp(mk_stamp(2005, 14, 1, 1, 0, 17));
        send_stamp(mk_stamp(2005, 5, 0, 0, 0, 18));

        // raw register extremes, outside the nominal offset range
        write_offset(11'h400);
        send_stamp(mk_stamp(2020, 1, 1, 0, 0, 19));
        send_stamp(mk_stamp(2020, 1, 1, 31, 63, 20));
        write_offset(11'h3FF);
        send_stamp(mk_stamp(2020, 12, 31, 31, 63, 21));
        send_stamp(mk_stamp(2020, 12, 31, 0, 0, 22));

        for (ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: off = 11'(0);
                1: off = 11'(-720);
                2: off = 11'(840);
                4: off = 11'h400;
                5: off = 11'h3FF;
                6: off = 11'($urandom_range(0, 2047));
                default: off = 11'($urandom_range(0, 1560) - 720);
            endcase
            write_offset(off);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 73; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 73; end
                default: begin src_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            repeat (PhaseBeats) begin
                case ($urandom_range(0, 9))
                    0: u.year = 16'($urandom_range(0, 163) * 400);
                    1: u.year = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
                    2: u.year = 16'(1900 + $urandom_range(0, 250));
                    default: u.year = 16'($urandom_range(0, 65535));
                endcase
                u.month = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12))
                                                       : 4'($urandom_range(0, 15));
                if ($urandom_range(0, 99) < 60) begin
                    case ($urandom_range(0, 5))
                        0: u.day = 5'd0;
                        1: u.day = 5'd1;
                        2: u.day = 5'd28;
                        3: u.day = 5'd29;
                        4: u.day = 5'd30;
                        default: u.day = 5'd31;
                    endcase
                end else begin
                    u.day = 5'($urandom_range(0, 31));
                end
                if ($urandom_range(0, 99) < 90) begin
                    u.hour   = 5'($urandom_range(0, 23));
                    u.minute = 6'($urandom_range(0, 59));
                end else begin
                    u.hour   = 5'($urandom_range(0, 31));
                    u.minute = 6'($urandom_range(0, 63));
                end
                u.second = 6'($urandom_range(0, 63));
                send_stamp(u);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/uoda_pkg.sv
design/uoda_time_calc.sv
design/uoda_date_step.sv
design/utc_offset_date_adjust_core.sv
test/utc_offset_date_adjust_core_tb.sv
